### rtl/core/spi_flash_command_engine_macros.svh
// assertion macros used by the checker file
`ifndef SPI_FLASH_COMMAND_ENGINE_MACROS_SVH
`define SPI_FLASH_COMMAND_ENGINE_MACROS_SVH

// antecedent implies consequent in the same cycle, outside reset
`define SFCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, outside reset
`define SFCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// checked on every edge, reset included
`define SFCE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) (expr)) else $error(msg);

`endif

### rtl/core/sfce_pkg.sv
// ----------------------------------------------------------------------------
// sfce_pkg
// Command codes, opcodes and register indexes of the SPI flash command engine.
// ----------------------------------------------------------------------------
package sfce_pkg;

    typedef enum logic [3:0] {
        CMD_IDLE = 4'd0,
        CMD_WRSR = 4'd1,
        CMD_PP   = 4'd2,
        CMD_READ = 4'd3,
        CMD_RDSR = 4'd4,
        CMD_FAST = 4'd5,
        CMD_SE   = 4'd6,
        CMD_REMS = 4'd7,
        CMD_RDID = 4'd8,
        CMD_QUAD = 4'd9
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic known;
    } decode_t;

    // host opcodes
    localparam logic [7:0] OPC_WRSR = 8'h01;
    localparam logic [7:0] OPC_PP   = 8'h02;
    localparam logic [7:0] OPC_READ = 8'h03;
    localparam logic [7:0] OPC_WRDI = 8'h04;
    localparam logic [7:0] OPC_RDSR = 8'h05;
    localparam logic [7:0] OPC_WREN = 8'h06;
    localparam logic [7:0] OPC_FAST = 8'h0B;
    localparam logic [7:0] OPC_SE   = 8'h20;
    localparam logic [7:0] OPC_REMS = 8'h90;
    localparam logic [7:0] OPC_RDID = 8'h9F;
    localparam logic [7:0] OPC_RES  = 8'hAB;
    localparam logic [7:0] OPC_DP   = 8'hB9;
    localparam logic [7:0] OPC_QUAD = 8'hEB;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RDSR_TWO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRSR_TWO  = 3'd4;

    // last address step (exclusive) per read flavor: 3 address bytes plus dummies
    localparam logic [2:0] STEP_END_PLAIN = 3'd3;
    localparam logic [2:0] STEP_END_FAST  = 3'd4;
    localparam logic [2:0] STEP_END_QUAD  = 3'd6;
    localparam logic [2:0] REMS_LAST      = 3'd4;

    function automatic decode_t decode_opcode(input logic [7:0] opc);
        decode_t d;
        d.known = 1'b1;
        d.cmd   = CMD_IDLE;
        case (opc)
            OPC_WRSR: d.cmd = CMD_WRSR;
            OPC_RDID: d.cmd = CMD_RDID;
            OPC_READ: d.cmd = CMD_READ;
            OPC_RDSR: d.cmd = CMD_RDSR;
            OPC_FAST: d.cmd = CMD_FAST;
            OPC_PP:   d.cmd = CMD_PP;
            OPC_SE:   d.cmd = CMD_SE;
            OPC_REMS: d.cmd = CMD_REMS;
            OPC_QUAD: d.cmd = CMD_QUAD;
            OPC_WREN, OPC_WRDI, OPC_RES, OPC_DP: d.cmd = CMD_IDLE;
            default:  d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/sfce_store.sv
// ----------------------------------------------------------------------------
// sfce_store
// Byte store of the flash: one address port for writes and for reads with registered data.
// ----------------------------------------------------------------------------
module sfce_store #(
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] index,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[index] <= wdata;
        end
        // read data holds until the next read
        if (rd_en) begin
            rdata_reg <= mem[index];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/spi_flash_command_engine.sv
// ----------------------------------------------------------------------------
// spi_flash_command_engine
// Byte-level SPI NOR flash slave: command decode, address collection,
// read / program against the byte store, status and ID answers.
// ----------------------------------------------------------------------------
//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------
//  s_       | in        | s_valid, s_ready, s_op, s_data_in
//  m_       | out       | m_valid, m_ready, m_data_out, m_bad_command
//  cfg_     | in        | cfg_wr_en, cfg_index, cfg_wdata
//
//  One item per cycle while s_ready is high; a result passes through the
//  pending stage (latch or the store's registered read port), then the output
//  register. A stalled output holds one result plus one in flight before
//  s_ready drops. Reset is synchronous; the store is not cleared.
// ----------------------------------------------------------------------------
module spi_flash_command_engine
    import sfce_pkg::*;
#(
    parameter int unsigned STORE_BYTES = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [7:0]           s_data_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_data_out,
    output logic                 m_bad_command,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(STORE_BYTES);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(STORE_BYTES - 1);

    cmd_t        cmd_reg, cmd_next;
    logic [2:0]  step_reg, step_next;
    logic [23:0] addr_reg, addr_next;
    logic [7:0]  latch_reg, latch_next;
    logic        latch_mem_reg, latch_mem_next;
    logic        bad_next;

    logic        pend_valid_reg, pend_bad_reg;
    logic        out_valid_reg, out_bad_reg;
    logic [7:0]  out_data_reg;

    logic [7:0]  id_first_reg, id_second_reg, id_third_reg;
    logic        rdsr_two_reg, wrsr_two_reg;

    logic        accept, pend_move;
    logic        st_wr, st_rd;
    logic [7:0]  st_rdata, latch_view;
    logic [2:0]  step_end;
    logic        addr_phase;
    decode_t     dec;

    assign pend_move = pend_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !pend_valid_reg || pend_move;
    assign accept    = s_valid && s_ready;

    // latch lives either in latch_reg or in the store's read register
    assign latch_view = latch_mem_reg ? st_rdata : latch_reg;

    assign dec = decode_opcode(s_data_in);

    always_comb begin
        case (cmd_reg)
            CMD_FAST: step_end = STEP_END_FAST;
            CMD_QUAD: step_end = STEP_END_QUAD;
            default:  step_end = STEP_END_PLAIN;
        endcase
    end

    assign addr_phase = step_reg < step_end;

    always_comb begin
        cmd_next       = cmd_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        latch_next     = latch_reg;
        latch_mem_next = latch_mem_reg;
        bad_next       = 1'b0;
        st_wr          = 1'b0;
        st_rd          = 1'b0;
        if (s_op) begin
            cmd_next  = CMD_IDLE;
            step_next = 3'd0;
        end else begin
            case (cmd_reg)
                CMD_IDLE: begin
                    cmd_next  = dec.cmd;
                    step_next = 3'd0;
                    bad_next  = !dec.known;
                end
                CMD_WRSR: begin
                    if (step_reg == 3'd0 && wrsr_two_reg) begin
                        step_next = 3'd1;
                    end else begin
                        cmd_next = CMD_IDLE;
                    end
                end
                CMD_RDSR: begin
                    latch_next     = 8'h00;
                    latch_mem_next = 1'b0;
                    if (step_reg == 3'd0 && rdsr_two_reg) begin
                        step_next = 3'd1;
                    end else begin
                        cmd_next = CMD_IDLE;
                    end
                end
                CMD_REMS: begin
                    if (step_reg < REMS_LAST) begin
                        step_next = step_reg + 3'd1;
                    end else begin
                        cmd_next = CMD_IDLE;
                    end
                end
                CMD_RDID: begin
                    latch_mem_next = 1'b0;
                    if (step_reg == 3'd0) begin
                        latch_next = id_first_reg;
                        step_next  = 3'd1;
                    end else if (step_reg == 3'd1) begin
                        latch_next = id_second_reg;
                        step_next  = 3'd2;
                    end else begin
                        latch_next = id_third_reg;
                        cmd_next   = CMD_IDLE;
                    end
                end
                CMD_READ, CMD_FAST, CMD_QUAD, CMD_PP, CMD_SE: begin
                    if (addr_phase) begin
                        // address bytes arrive msb first, then dummies
                        case (step_reg)
                            3'd0:    addr_next[23:16] = s_data_in;
                            3'd1:    addr_next[15:8]  = s_data_in;
                            3'd2:    addr_next[7:0]   = s_data_in;
                            default: addr_next        = addr_reg;
                        endcase
                        step_next = step_reg + 3'd1;
                    end else if (cmd_reg == CMD_PP) begin
                        st_wr     = 1'b1;
                        addr_next = addr_reg + 24'd1;
                    end else if (cmd_reg != CMD_SE) begin
                        st_rd          = 1'b1;
                        latch_mem_next = 1'b1;
                        addr_next      = addr_reg + 24'd1;
                    end
                end
                default: begin
                    cmd_next  = CMD_IDLE;
                    step_next = 3'd0;
                end
            endcase
        end
    end

    sfce_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk  (aclk),
        .wr_en (accept && st_wr),
        .rd_en (accept && st_rd),
        .index (addr_reg[IDX_W-1:0] & IDX_MASK),
        .wdata (s_data_in),
        .rdata (st_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= CMD_IDLE;
            step_reg       <= 3'd0;
            addr_reg       <= 24'd0;
            latch_reg      <= 8'h00;
            latch_mem_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_bad_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_bad_reg    <= 1'b0;
            out_data_reg   <= 8'h00;
        end else begin
            if (accept) begin
                cmd_reg       <= cmd_next;
                step_reg      <= step_next;
                addr_reg      <= addr_next;
                latch_reg     <= latch_next;
                latch_mem_reg <= latch_mem_next;
                pend_bad_reg  <= bad_next;
            end
            if (accept) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_move) begin
                pend_valid_reg <= 1'b0;
            end
            // the latch view before this edge belongs to the pending item
            if (pend_move) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= latch_view;
                out_bad_reg   <= pend_bad_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_first_reg  <= 8'hFE;
            id_second_reg <= 8'hFE;
            id_third_reg  <= 8'h00;
            rdsr_two_reg  <= 1'b1;
            wrsr_two_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ID_FIRST:  id_first_reg  <= cfg_wdata;
                CFG_ID_SECOND: id_second_reg <= cfg_wdata;
                CFG_ID_THIRD:  id_third_reg  <= cfg_wdata;
                CFG_RDSR_TWO:  rdsr_two_reg  <= cfg_wdata[0];
                CFG_WRSR_TWO:  wrsr_two_reg  <= cfg_wdata[0];
                default:       id_first_reg  <= id_first_reg;
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data_out    = out_data_reg;
    assign m_bad_command = out_bad_reg;

endmodule

### rtl/core/sfce_checker.sv
// ----------------------------------------------------------------------------
// sfce_checker
// Port-level checks of the SPI flash command engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "spi_flash_command_engine_macros.svh"

module sfce_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_data_out,
    input logic       m_bad_command
);

    // a result that waits keeps its value
    `SFCE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_data_out) && $stable(m_bad_command),
        "result changed while stalled")
    // empty output slot never blocks the input
    `SFCE_ASSERT_IMP(a_ready_when_empty, !m_valid, s_ready,
        "input blocked with empty output")
    // every taken item shows a result once past the pending and output registers
    `SFCE_ASSERT_IMP(a_result_latency, s_valid && s_ready, ##2 m_valid,
        "result missing after item")
    // nothing comes out right after reset; the very first edge sees no reset yet
    `SFCE_ASSERT_ALWAYS(a_reset_empty, !$past(!aresetn) || m_valid !== 1'b1,
        "result valid after reset")

endmodule

bind spi_flash_command_engine sfce_checker u_sfce_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_out    (m_data_out),
    .m_bad_command (m_bad_command)
);
